// ===== rtl/acmac_pkg.sv =====
// shared types, constants and aes helper functions for the cmac engine
`timescale 1ns / 1ps
`default_nettype none
package acmac_pkg;

  localparam int BLK_W = 128;

  // configuration register indexes
  typedef enum logic [2:0] {
    REG_KEY0 = 3'd0,
    REG_KEY1 = 3'd1,
    REG_KEY2 = 3'd2,
    REG_KEY3 = 3'd3,
    REG_MODE = 3'd4
  } reg_idx_t;

  localparam logic [1:0] MODE_128 = 2'd0;
  localparam logic [1:0] MODE_192 = 2'd1;

  localparam logic [7:0] RB_CONST  = 8'h87;
  localparam logic [7:0] PAD_BYTE  = 8'h80;
  localparam logic [4:0] FULL_CNT  = 5'd16;

  // prepared word from front to back
  typedef struct packed {
    logic [BLK_W-1:0] data;
    logic             use_k1;
    logic             use_k2;
    logic             last;
  } job_t;

  localparam logic [7:0] SBOX [256] = '{
    8'h63,8'h7c,8'h77,8'h7b,8'hf2,8'h6b,8'h6f,8'hc5,8'h30,8'h01,8'h67,8'h2b,8'hfe,8'hd7,8'hab,8'h76,
    8'hca,8'h82,8'hc9,8'h7d,8'hfa,8'h59,8'h47,8'hf0,8'had,8'hd4,8'ha2,8'haf,8'h9c,8'ha4,8'h72,8'hc0,
    8'hb7,8'hfd,8'h93,8'h26,8'h36,8'h3f,8'hf7,8'hcc,8'h34,8'ha5,8'he5,8'hf1,8'h71,8'hd8,8'h31,8'h15,
    8'h04,8'hc7,8'h23,8'hc3,8'h18,8'h96,8'h05,8'h9a,8'h07,8'h12,8'h80,8'he2,8'heb,8'h27,8'hb2,8'h75,
    8'h09,8'h83,8'h2c,8'h1a,8'h1b,8'h6e,8'h5a,8'ha0,8'h52,8'h3b,8'hd6,8'hb3,8'h29,8'he3,8'h2f,8'h84,
    8'h53,8'hd1,8'h00,8'hed,8'h20,8'hfc,8'hb1,8'h5b,8'h6a,8'hcb,8'hbe,8'h39,8'h4a,8'h4c,8'h58,8'hcf,
    8'hd0,8'hef,8'haa,8'hfb,8'h43,8'h4d,8'h33,8'h85,8'h45,8'hf9,8'h02,8'h7f,8'h50,8'h3c,8'h9f,8'ha8,
    8'h51,8'ha3,8'h40,8'h8f,8'h92,8'h9d,8'h38,8'hf5,8'hbc,8'hb6,8'hda,8'h21,8'h10,8'hff,8'hf3,8'hd2,
    8'hcd,8'h0c,8'h13,8'hec,8'h5f,8'h97,8'h44,8'h17,8'hc4,8'ha7,8'h7e,8'h3d,8'h64,8'h5d,8'h19,8'h73,
    8'h60,8'h81,8'h4f,8'hdc,8'h22,8'h2a,8'h90,8'h88,8'h46,8'hee,8'hb8,8'h14,8'hde,8'h5e,8'h0b,8'hdb,
    8'he0,8'h32,8'h3a,8'h0a,8'h49,8'h06,8'h24,8'h5c,8'hc2,8'hd3,8'hac,8'h62,8'h91,8'h95,8'he4,8'h79,
    8'he7,8'hc8,8'h37,8'h6d,8'h8d,8'hd5,8'h4e,8'ha9,8'h6c,8'h56,8'hf4,8'hea,8'h65,8'h7a,8'hae,8'h08,
    8'hba,8'h78,8'h25,8'h2e,8'h1c,8'ha6,8'hb4,8'hc6,8'he8,8'hdd,8'h74,8'h1f,8'h4b,8'hbd,8'h8b,8'h8a,
    8'h70,8'h3e,8'hb5,8'h66,8'h48,8'h03,8'hf6,8'h0e,8'h61,8'h35,8'h57,8'hb9,8'h86,8'hc1,8'h1d,8'h9e,
    8'he1,8'hf8,8'h98,8'h11,8'h69,8'hd9,8'h8e,8'h94,8'h9b,8'h1e,8'h87,8'he9,8'hce,8'h55,8'h28,8'hdf,
    8'h8c,8'ha1,8'h89,8'h0d,8'hbf,8'he6,8'h42,8'h68,8'h41,8'h99,8'h2d,8'h0f,8'hb0,8'h54,8'hbb,8'h16
  };

  function automatic logic [7:0] xtime(input logic [7:0] v);
    return {v[6:0], 1'b0} ^ (v[7] ? 8'h1b : 8'h00);
  endfunction

  function automatic logic [31:0] sub_word(input logic [31:0] w);
    return {SBOX[w[31:24]], SBOX[w[23:16]], SBOX[w[15:8]], SBOX[w[7:0]]};
  endfunction

  // subbytes, shiftrows and optional mixcolumns; byte 0 in bits 127:120
  function automatic logic [127:0] aes_round(input logic [127:0] s, input logic mix);
    logic [7:0] b [16];
    logic [7:0] t [16];
    logic [7:0] a0, a1, a2, a3, al;
    logic [127:0] r;
    for (int i = 0; i < 16; i++) b[i] = s[127-8*i -: 8];
    for (int c = 0; c < 4; c++) begin
      for (int row = 0; row < 4; row++) begin
        t[row+4*c] = SBOX[b[row+4*((c+row)%4)]];
      end
    end
    if (mix) begin
      for (int c = 0; c < 4; c++) begin
        a0 = t[4*c]; a1 = t[4*c+1]; a2 = t[4*c+2]; a3 = t[4*c+3];
        al = a0 ^ a1 ^ a2 ^ a3;
        t[4*c]   = a0 ^ al ^ xtime(a0 ^ a1);
        t[4*c+1] = a1 ^ al ^ xtime(a1 ^ a2);
        t[4*c+2] = a2 ^ al ^ xtime(a2 ^ a3);
        t[4*c+3] = a3 ^ al ^ xtime(a3 ^ a0);
      end
    end
    for (int i = 0; i < 16; i++) r[127-8*i -: 8] = t[i];
    return r;
  endfunction

  // gf(2^128) doubling used for subkey derivation
  function automatic logic [127:0] dbl(input logic [127:0] v);
    return {v[126:0], 1'b0} ^ {120'd0, (v[127] ? RB_CONST : 8'h00)};
  endfunction

endpackage
`default_nettype wire

// ===== rtl/acmac_front.sv =====
// front end: pads and classifies message words into a small queue
`timescale 1ns / 1ps
`default_nettype none
module acmac_front (
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire logic               in_valid,
  output logic                    in_stall,
  input  wire logic [63:0]        block_hi,
  input  wire logic [63:0]        block_lo,
  input  wire logic [4:0]         byte_count,
  input  wire logic               last_block,
  output logic                    job_valid,
  input  wire logic               job_take,
  output acmac_pkg::job_t         job
);
  import acmac_pkg::*;

  localparam int DEPTH = 2;

  job_t         q [DEPTH];
  logic         wr_ptr, rd_ptr;
  logic [1:0]   count;
  logic         push, pop;
  job_t         fresh;
  logic [127:0] raw, mask, padded;
  logic [4:0]   cnt;

  // pad a short last word
  always_comb begin
    raw = {block_hi, block_lo};
    cnt = byte_count;
    mask = '0;
    padded = '0;
    for (int i = 0; i < 16; i++) begin
      if (5'(i) < cnt) mask[127-8*i -: 8] = 8'hff;
      if (5'(i) == cnt) padded[127-8*i -: 8] = PAD_BYTE;
    end
    padded = padded | (raw & mask);
    fresh.last = last_block;
    fresh.use_k1 = last_block && (cnt >= FULL_CNT);
    fresh.use_k2 = last_block && (cnt < FULL_CNT);
    fresh.data = fresh.use_k2 ? padded : raw;
  end

  assign in_stall  = (count == 2'(DEPTH));
  assign push      = in_valid && !in_stall;
  assign job_valid = (count != 2'd0);
  assign pop       = job_valid && job_take;
  assign job       = q[rd_ptr];

  // queue storage
  always_ff @(posedge clk) begin
    if (push) q[wr_ptr] <= fresh;
  end

  // queue pointers
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      count  <= 2'd0;
    end else begin
      if (push) wr_ptr <= ~wr_ptr;
      if (pop) rd_ptr <= ~rd_ptr;
      count <= count + 2'(push) - 2'(pop);
    end
  end

  a_no_overflow: assert property (@(posedge clk) disable iff (rst) count <= 2'(DEPTH))
    else $error("queue count out of range");
  a_pop_nonempty: assert property (@(posedge clk) disable iff (rst)
    pop |-> count != 2'd0) else $error("pop from empty queue");
  a_k_excl: assert property (@(posedge clk) disable iff (rst)
    push |-> !(fresh.use_k1 && fresh.use_k2)) else $error("both subkeys chosen");

endmodule
`default_nettype wire

// ===== rtl/acmac_back.sv =====
// back end: iterative aes round unit, subkey derivation, chaining and tag output
`timescale 1ns / 1ps
`default_nettype none
module acmac_back (
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire logic [255:0]       key,
  input  wire logic [1:0]         key_mode,
  input  wire logic               key_write,
  input  wire logic               job_valid,
  output logic                    job_take,
  input  wire acmac_pkg::job_t    job,
  output logic                    out_valid,
  input  wire logic               out_stall,
  output logic [63:0]             tag_hi,
  output logic [63:0]             tag_lo
);
  import acmac_pkg::*;

  typedef enum logic [2:0] {
    S_IDLE, S_KEYLOAD, S_RUN, S_DONE, S_HOLD
  } state_t;

  state_t       state;
  logic [127:0] st, chain, k1, k2;
  logic         rdy, deriving, cur_last;
  // rolling key schedule window of nk words
  logic [31:0]  kw [8];
  logic [3:0]   nk;
  logic [3:0]   nr;
  logic [5:0]   widx;
  logic [3:0]   rnd;
  logic [7:0]   rcon;
  logic [4:0]   sub_i;
  logic [127:0] rk, start_in, l_val;
  logic [31:0]  nw, tmp;
  logic [127:0] rout;

  assign nk = (key_mode == MODE_128) ? 4'd4 : (key_mode == MODE_192) ? 4'd6 : 4'd8;
  assign nr = nk + 4'd6;

  // next expanded key word from the window
  always_comb begin
    tmp = kw[3'(nk - 4'd1)];
    if (sub_i == 5'd0) tmp = sub_word({tmp[23:0], tmp[31:24]}) ^ {rcon, 24'd0};
    else if (nk == 4'd8 && sub_i == 5'd4) tmp = sub_word(tmp);
    nw = kw[0] ^ tmp;
  end

  // round key: the four oldest window words
  assign rk = {kw[0], kw[1], kw[2], kw[3]};
  assign rout = aes_round(st, rnd != nr);
  assign start_in = job.data ^ chain ^ (job.use_k1 ? k1 : 128'd0) ^ (job.use_k2 ? k2 : 128'd0);
  assign l_val = st;
  // the head word is removed once its data has been loaded into the state
  assign job_take = (state == S_KEYLOAD) && !deriving;

  // round sequencer; the key window shifts 4 words per round
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      rdy <= 1'b0;
      chain <= '0;
      out_valid <= 1'b0;
      deriving <= 1'b0;
    end else begin
      if (key_write) rdy <= 1'b0;
      case (state)
        S_IDLE: begin
          if (job_valid) begin
            for (int i = 0; i < 8; i++) kw[i] <= key[255-32*i -: 32];
            state <= S_KEYLOAD;
            deriving <= !rdy;
          end
        end
        S_KEYLOAD: begin
          st <= (deriving ? 128'd0 : start_in) ^ rk;
          cur_last <= job.last;
          rnd <= 4'd1;
          rcon <= 8'h01;
          sub_i <= 5'd0;
          widx <= 6'(nk);
          state <= S_HOLD;
        end
        S_HOLD: begin
          // shift the window one word and append the new word
          for (int i = 0; i < 7; i++) kw[i] <= (4'(i) == nk - 4'd1) ? nw : kw[i+1];
          if (nk == 4'd8) kw[7] <= nw;
          sub_i <= (sub_i + 5'd1 == 5'(nk)) ? 5'd0 : sub_i + 5'd1;
          if (sub_i + 5'd1 == 5'(nk)) rcon <= xtime(rcon);
          widx <= widx + 6'd1;
          if (((widx + 6'd1 - 6'(nk)) & 6'd3) == 6'd0) state <= S_RUN;
        end
        S_RUN: begin
          st <= rout ^ rk;
          if (rnd == nr) begin
            state <= S_DONE;
          end else begin
            rnd <= rnd + 4'd1;
            state <= S_HOLD;
          end
        end
        S_DONE: begin
          if (deriving) begin
            k1 <= dbl(l_val);
            k2 <= dbl(dbl(l_val));
            rdy <= 1'b1;
            deriving <= 1'b0;
            state <= S_IDLE;
          end else if (cur_last) begin
            if (!out_valid || !out_stall) begin
              tag_hi <= st[127:64];
              tag_lo <= st[63:0];
              out_valid <= 1'b1;
              chain <= '0;
              state <= S_IDLE;
            end
          end else begin
            chain <= st;
            state <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
      if (out_valid && !out_stall && !(state == S_DONE && cur_last && !deriving))
        out_valid <= 1'b0;
    end
  end

  a_take_ready: assert property (@(posedge clk) disable iff (rst) job_take |-> rdy)
    else $error("job taken without subkeys");
  a_out_last: assert property (@(posedge clk) disable iff (rst)
    $rose(out_valid) |-> $past(cur_last)) else $error("tag from non-last word");
  a_round_bound: assert property (@(posedge clk) disable iff (rst)
    state == S_RUN |-> rnd <= nr) else $error("round count overrun");

endmodule
`default_nettype wire

// ===== rtl/aes_cmac_engine.sv =====
// top level of the aes-cmac engine
`timescale 1ns / 1ps
`default_nettype none
// aes-cmac tag engine.
// input channel (in_valid / in_stall) takes one 16-byte message word with
// byte_count and last_block; the output channel (out_valid / out_stall)
// carries one 128-bit tag per message, after its last word.
// key registers are written on the cfg channel (cfg_valid / cfg_ready, always
// ready); the user must write them only while the block is idle, which the
// block does not enforce; any key write forces subkey derivation on the next
// word, which costs one extra aes pass.
// each word takes one aes pass on a single round unit: per round the key
// schedule appends four words, one word a cycle, and then one round step runs.
// a two-entry queue decouples word intake from the round unit; the tag
// register holds while out_stall is high and the next message still runs.
// reset clears the queue, the chain and the subkey flag; keys reset to zero.
module aes_cmac_engine (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        in_valid,
  output logic             in_stall,
  input  wire logic [63:0] block_hi,
  input  wire logic [63:0] block_lo,
  input  wire logic [4:0]  byte_count,
  input  wire logic        last_block,
  output logic             out_valid,
  input  wire logic        out_stall,
  output logic [63:0]      tag_hi,
  output logic [63:0]      tag_lo,
  input  wire logic        cfg_valid,
  output logic             cfg_ready,
  input  wire logic [2:0]  cfg_index,
  input  wire logic [63:0] cfg_data
);
  import acmac_pkg::*;

  logic [63:0]  key_w [4];
  logic [1:0]   mode;
  logic         kwr;
  logic         job_valid, job_take;
  job_t         job;

  assign cfg_ready = 1'b1;
  assign kwr = cfg_valid && (cfg_index <= 3'(REG_MODE));

  // key registers
  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < 4; i++) key_w[i] <= '0;
      mode <= MODE_128;
    end else if (cfg_valid) begin
      case (reg_idx_t'(cfg_index))
        REG_KEY0: key_w[0] <= cfg_data;
        REG_KEY1: key_w[1] <= cfg_data;
        REG_KEY2: key_w[2] <= cfg_data;
        REG_KEY3: key_w[3] <= cfg_data;
        REG_MODE: mode <= cfg_data[1:0];
        default: ;
      endcase
    end
  end

  acmac_front u_front (
    .clk, .rst, .in_valid, .in_stall, .block_hi, .block_lo, .byte_count,
    .last_block, .job_valid, .job_take, .job
  );

  acmac_back u_back (
    .clk, .rst,
    .key({key_w[0], key_w[1], key_w[2], key_w[3]}),
    .key_mode(mode), .key_write(kwr),
    .job_valid, .job_take, .job, .out_valid, .out_stall, .tag_hi, .tag_lo
  );

  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid && $stable(tag_hi) && $stable(tag_lo))
    else $error("tag changed under stall");
  a_in_hold: assert property (@(posedge clk) disable iff (rst)
    in_stall |=> !job_take || $past(job_valid)) else $error("queue underflow");
  a_cfg_rdy: assert property (@(posedge clk) cfg_ready) else $error("cfg not ready");

endmodule
`default_nettype wire
